FILE: hw/rtl/oll_pkg.sv
// Shared constants, codes and types for the ordered list block.
// Depends on nothing; every other file of the block imports it.
package oll_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IDX_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic signed [VALUE_W-1:0]  value_t;
	typedef logic [KIND_W-1:0]          kind_t;
	typedef logic [STATUS_W-1:0]        status_t;
	typedef logic [COUNT_W-1:0]         count_t;

	localparam idx_t NIL = idx_t'(CAPACITY);

	localparam kind_t KIND_PUSH_FRONT = 2'd0;
	localparam kind_t KIND_PUSH_BACK  = 2'd1;
	localparam kind_t KIND_REMOVE     = 2'd2;
	localparam kind_t KIND_SEARCH     = 2'd3;

	localparam status_t STATUS_DONE      = 2'd0;
	localparam status_t STATUS_FULL      = 2'd1;
	localparam status_t STATUS_NOT_FOUND = 2'd2;

	typedef struct packed {
		addr_t  rd_addr;
		logic   val_we;
		addr_t  val_addr;
		value_t val_data;
		logic   fwd_we;
		addr_t  fwd_addr;
		idx_t   fwd_data;
		logic   bwd_we;
		addr_t  bwd_addr;
		idx_t   bwd_data;
	} mem_req_t;

	typedef struct packed {
		value_t value;
		idx_t   fwd;
		idx_t   bwd;
	} mem_rsp_t;

	function automatic logic is_node(idx_t i);
		return i < NIL;
	endfunction

	function automatic addr_t to_addr(idx_t i);
		return i[ADDR_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/oll_req_if.sv
// Request channel of the ordered list block: valid, ready and request payload.
// Depends on oll_pkg for field widths.
interface oll_req_if import oll_pkg::*; ();
	logic   valid;
	logic   ready;
	kind_t  kind;
	value_t item_value;

	modport source (output valid, output kind, output item_value, input ready);
	modport sink (input valid, input kind, input item_value, output ready);
endinterface

FILE: hw/rtl/oll_rsp_if.sv
// Result channel of the ordered list block: valid, ready and result payload.
// Depends on oll_pkg for field widths.
interface oll_rsp_if import oll_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	logic    found;
	count_t  entry_count;

	modport source (output valid, output status, output found, output entry_count, input ready);
	modport sink (input valid, input status, input found, input entry_count, output ready);
endinterface

FILE: hw/rtl/oll_mem.sv
// Node pool storage: values, forward links and backward links, one read port
// with registered data and one write port per array. Depends on oll_pkg.
module oll_mem import oll_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	value_t val_mem [CAPACITY];
	idx_t   fwd_mem [CAPACITY];
	idx_t   bwd_mem [CAPACITY];
	logic [CAPACITY-1:0] fwd_vld_q;
	value_t val_rd_q;
	idx_t   bwd_rd_q;
	idx_t   fwd_rd_q;
	logic   fwd_rd_vld_q;
	addr_t  rd_addr_q;

	always_ff @(posedge clk) begin
		if (req.val_we) begin
			val_mem[req.val_addr] <= req.val_data;
		end
		if (req.fwd_we) begin
			fwd_mem[req.fwd_addr] <= req.fwd_data;
		end
		if (req.bwd_we) begin
			bwd_mem[req.bwd_addr] <= req.bwd_data;
		end
		val_rd_q  <= val_mem[req.rd_addr];
		bwd_rd_q  <= bwd_mem[req.rd_addr];
		fwd_rd_q  <= fwd_mem[req.rd_addr];
		rd_addr_q <= req.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q    <= '0;
			fwd_rd_vld_q <= 1'b0;
		end else begin
			fwd_rd_vld_q <= fwd_vld_q[req.rd_addr];
			if (req.fwd_we) begin
				fwd_vld_q[req.fwd_addr] <= 1'b1;
			end
		end
	end

	// unwritten forward links read as the reset free chain
	always_comb begin
		rsp.value = val_rd_q;
		rsp.bwd   = bwd_rd_q;
		rsp.fwd   = fwd_rd_vld_q ? fwd_rd_q : idx_t'(rd_addr_q) + idx_t'(1);
	end

endmodule

FILE: hw/rtl/oll_ctrl.sv
// Request sequencer: pushes, list walks and unlinks over the node pool, plus
// head, tail, free list and count registers. Depends on oll_pkg and both channel interfaces.
module oll_ctrl import oll_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	oll_req_if.sink       req,
	oll_rsp_if.source     rsp,
	output mem_req_t      mreq,
	input  mem_rsp_t      mrsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_W1,
		ST_PUSH_W2,
		ST_WALK,
		ST_UNLINK1,
		ST_UNLINK2,
		ST_FIN
	} state_t;

	state_t  state_q;
	kind_t   kind_q;
	value_t  value_q;
	idx_t    head_q;
	idx_t    tail_q;
	idx_t    free_q;
	idx_t    count_q;
	idx_t    cur_q;
	idx_t    steps_q;
	idx_t    prv_q;
	idx_t    nxt_q;
	status_t res_status_q;
	logic    res_found_q;
	logic    out_valid_q;
	status_t out_status_q;
	logic    out_found_q;
	count_t  out_count_q;

	logic is_push;
	logic front;

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found       = out_found_q;
	assign rsp.entry_count = out_count_q;

	assign is_push = (req.kind == KIND_PUSH_FRONT) || (req.kind == KIND_PUSH_BACK);
	assign front   = (kind_q == KIND_PUSH_FRONT);

	always_comb begin
		mreq = '0;
		case (state_q)
			ST_IDLE: begin
				mreq.rd_addr = is_push ? to_addr(free_q) : to_addr(head_q);
			end
			ST_PUSH_W1: begin
				mreq.val_we   = 1'b1;
				mreq.val_addr = to_addr(cur_q);
				mreq.val_data = value_q;
				mreq.fwd_we   = 1'b1;
				mreq.fwd_addr = to_addr(cur_q);
				mreq.fwd_data = front ? head_q : NIL;
				mreq.bwd_we   = 1'b1;
				mreq.bwd_addr = to_addr(cur_q);
				mreq.bwd_data = front ? NIL : tail_q;
			end
			ST_PUSH_W2: begin
				mreq.bwd_we   = front && is_node(head_q);
				mreq.bwd_addr = to_addr(head_q);
				mreq.bwd_data = cur_q;
				mreq.fwd_we   = !front && is_node(tail_q);
				mreq.fwd_addr = to_addr(tail_q);
				mreq.fwd_data = cur_q;
			end
			ST_WALK: begin
				mreq.rd_addr = to_addr(mrsp.fwd);
			end
			ST_UNLINK1: begin
				mreq.bwd_we   = is_node(nxt_q);
				mreq.bwd_addr = to_addr(nxt_q);
				mreq.bwd_data = prv_q;
				mreq.fwd_we   = is_node(prv_q);
				mreq.fwd_addr = to_addr(prv_q);
				mreq.fwd_data = nxt_q;
			end
			ST_UNLINK2: begin
				mreq.fwd_we   = 1'b1;
				mreq.fwd_addr = to_addr(cur_q);
				mreq.fwd_data = free_q;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_PUSH_FRONT;
			value_q      <= '0;
			head_q       <= NIL;
			tail_q       <= NIL;
			free_q       <= '0;
			count_q      <= '0;
			cur_q        <= '0;
			steps_q      <= '0;
			prv_q        <= '0;
			nxt_q        <= '0;
			res_status_q <= STATUS_DONE;
			res_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_DONE;
			out_found_q  <= 1'b0;
			out_count_q  <= '0;
		end else begin
			if (rsp.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						kind_q      <= req.kind;
						value_q     <= req.item_value;
						res_found_q <= 1'b0;
						steps_q     <= '0;
						if (is_push) begin
							cur_q <= free_q;
							if (is_node(free_q)) begin
								state_q <= ST_PUSH_W1;
							end else begin
								res_status_q <= STATUS_FULL;
								state_q      <= ST_FIN;
							end
						end else begin
							cur_q <= head_q;
							if (is_node(head_q)) begin
								state_q <= ST_WALK;
							end else begin
								res_status_q <= STATUS_NOT_FOUND;
								state_q      <= ST_FIN;
							end
						end
					end
				end
				ST_PUSH_W1: begin
					free_q  <= mrsp.fwd;
					state_q <= ST_PUSH_W2;
				end
				ST_PUSH_W2: begin
					if (front) begin
						if (!is_node(head_q)) begin
							tail_q <= cur_q;
						end
						head_q <= cur_q;
					end else begin
						if (!is_node(tail_q)) begin
							head_q <= cur_q;
						end
						tail_q <= cur_q;
					end
					count_q      <= count_q + idx_t'(1);
					res_status_q <= STATUS_DONE;
					state_q      <= ST_FIN;
				end
				ST_WALK: begin
					if (mrsp.value == value_q) begin
						prv_q        <= mrsp.bwd;
						nxt_q        <= mrsp.fwd;
						res_status_q <= STATUS_DONE;
						res_found_q  <= 1'b1;
						state_q      <= (kind_q == KIND_REMOVE) ? ST_UNLINK1 : ST_FIN;
					end else if (!is_node(mrsp.fwd) || steps_q == NIL - idx_t'(1)) begin
						res_status_q <= STATUS_NOT_FOUND;
						state_q      <= ST_FIN;
					end else begin
						cur_q   <= mrsp.fwd;
						steps_q <= steps_q + idx_t'(1);
					end
				end
				ST_UNLINK1: begin
					if (!is_node(prv_q)) begin
						head_q <= nxt_q;
					end
					if (!is_node(nxt_q)) begin
						tail_q <= prv_q;
					end
					state_q <= ST_UNLINK2;
				end
				ST_UNLINK2: begin
					free_q  <= cur_q;
					count_q <= count_q - idx_t'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= res_found_q;
						out_count_q  <= count_t'(count_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/ordered_list_with_search.sv
// Ordered list with search: doubly linked list over a 64-node pool.
// Push: writes the new node, links it at the head or tail, then posts the result; a push
// into a full pool or a search or removal on an empty list skips straight to its result.
// Search/remove: walk from the head to the first match; a removal then unlinks and frees
// it; a miss walks the whole list. Ready returns with the result; a held result delays it.
// Reset: empty list, all nodes free; no clearing pass, ready right after reset.
module ordered_list_with_search import oll_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	oll_req_if.sink   req,
	oll_rsp_if.source rsp
);

	mem_req_t mreq;
	mem_rsp_t mrsp;

	oll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mreq   (mreq),
		.mrsp   (mrsp)
	);

	oll_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

endmodule

FILE: bench/tb_ordered_list_with_search.sv
`timescale 1ns / 1ps
// Self-checking bench for ordered_list_with_search: a list model in a scoreboard class
// predicts each result; plain tasks drive requests with bursts and gaps, an always block stalls results.
// Depends on oll_pkg, oll_req_if, oll_rsp_if and the ordered_list_with_search RTL.
module tb_ordered_list_with_search;
	import oll_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 100;

	typedef struct packed {
		status_t status;
		logic    found;
		count_t  entry_count;
	} list_outcome_t;

	class list_scoreboard;
		value_t        node_val[CAPACITY];
		idx_t          next_of[CAPACITY];
		idx_t          prev_of[CAPACITY];
		idx_t          head;
		idx_t          tail;
		idx_t          free_top;
		int unsigned   live;
		list_outcome_t awaited_outcomes[$];
		int unsigned   errors;

		function new();
			for (int i = 0; i < CAPACITY; i++) begin
				node_val[i] = '0;
				prev_of[i]  = '0;
				next_of[i]  = idx_t'(i + 1);
			end
			head     = NIL;
			tail     = NIL;
			free_top = '0;
			live     = 0;
			errors   = 0;
		endfunction

		function idx_t find_first(value_t v);
			idx_t cur;
			cur = head;
			for (int steps = 0; steps < CAPACITY && cur < NIL; steps++) begin
				if (node_val[to_addr(cur)] == v)
					return cur;
				cur = next_of[to_addr(cur)];
			end
			return NIL;
		endfunction

		function value_t pick_live();
			idx_t cur;
			int   hops;
			cur  = head;
			hops = $urandom_range(0, live - 1);
			for (int i = 0; i < hops; i++)
				cur = next_of[to_addr(cur)];
			return node_val[to_addr(cur)];
		endfunction

		function void note_request(kind_t k, value_t v);
			list_outcome_t o;
			idx_t          n;
			idx_t          p;
			idx_t          q;
			o.status = STATUS_DONE;
			o.found  = 1'b0;
			if (k == KIND_PUSH_FRONT || k == KIND_PUSH_BACK) begin
				n = free_top;
				if (n >= NIL) begin
					o.status = STATUS_FULL;
				end else begin
					free_top             = next_of[to_addr(n)];
					node_val[to_addr(n)] = v;
					if (k == KIND_PUSH_FRONT) begin
						prev_of[to_addr(n)] = NIL;
						next_of[to_addr(n)] = head;
						if (head < NIL)
							prev_of[to_addr(head)] = n;
						else
							tail = n;
						head = n;
					end else begin
						next_of[to_addr(n)] = NIL;
						prev_of[to_addr(n)] = tail;
						if (tail < NIL)
							next_of[to_addr(tail)] = n;
						else
							head = n;
						tail = n;
					end
					live++;
				end
			end else begin
				n = find_first(v);
				if (n >= NIL) begin
					o.status = STATUS_NOT_FOUND;
				end else begin
					o.found = 1'b1;
					if (k == KIND_REMOVE) begin
						p = prev_of[to_addr(n)];
						q = next_of[to_addr(n)];
						if (p < NIL)
							next_of[to_addr(p)] = q;
						else
							head = q;
						if (q < NIL)
							prev_of[to_addr(q)] = p;
						else
							tail = p;
						next_of[to_addr(n)] = free_top;
						free_top            = n;
						live--;
					end
				end
			end
			o.entry_count = count_t'(live);
			awaited_outcomes.push_back(o);
		endfunction

		function void check_result(status_t s, logic f, count_t c);
			list_outcome_t o;
			if (awaited_outcomes.size() == 0) begin
				$error("unexpected result: status=%0d found=%0d entry_count=%0d", s, f, c);
				errors++;
				return;
			end
			o = awaited_outcomes.pop_front();
			if (s !== o.status) begin
				$error("status: expected %0d, actual %0d", o.status, s);
				errors++;
			end
			if (f !== o.found) begin
				$error("found: expected %0d, actual %0d", o.found, f);
				errors++;
			end
			if (c !== o.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", o.entry_count, c);
				errors++;
			end
		endfunction

		function int outstanding();
			return awaited_outcomes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	oll_req_if req_ch();
	oll_rsp_if rsp_ch();

	ordered_list_with_search uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_scoreboard sb = new();

	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_run = 0;
	int unsigned stall_mode = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.status, rsp_ch.found, rsp_ch.entry_count);
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_run  = $urandom_range(8, 80);
		end
		stall_run--;
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= (stall_run % 16) >= 11;
		endcase
	end

	task automatic send_request(input kind_t k, input value_t v);
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= k;
		req_ch.item_value <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(k, v);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic value_t pick_value(int unsigned live_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (sb.live > 0 && r < live_pct)
			return sb.pick_live();
		r = $urandom_range(0, 9);
		case (r)
			0: return value_t'(32'h8000_0000);
			1: return value_t'(32'h7FFF_FFFF);
			2: return value_t'(32'h0000_0000);
			3: return value_t'(32'hFFFF_FFFF);
			4: return value_t'($urandom_range(0, 7));
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic run_phase(input int unsigned n_items, input int unsigned push_pct,
			input int unsigned remove_pct, input int unsigned live_pct);
		int unsigned r;
		kind_t       k;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct)
				k = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
			else if (r < push_pct + remove_pct)
				k = KIND_REMOVE;
			else
				k = KIND_SEARCH;
			send_request(k, pick_value(live_pct));
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.kind       <= KIND_PUSH_FRONT;
		req_ch.item_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: miss on search and removal
		send_request(KIND_SEARCH, value_t'(5));
		send_request(KIND_REMOVE, value_t'(5));
		send_request(KIND_PUSH_FRONT, value_t'(32'h7FFF_FFFF));
		send_request(KIND_PUSH_BACK, value_t'(32'h8000_0000));
		send_request(KIND_PUSH_FRONT, value_t'(0));
		send_request(KIND_PUSH_BACK, value_t'(32'hFFFF_FFFF));
		send_request(KIND_PUSH_BACK, value_t'(32'h7FFF_FFFF));
		send_request(KIND_SEARCH, value_t'(32'h8000_0000));
		send_request(KIND_SEARCH, value_t'(12345));
		// duplicates: drop the first match only
		send_request(KIND_REMOVE, value_t'(32'h7FFF_FFFF));
		send_request(KIND_SEARCH, value_t'(32'h7FFF_FFFF));
		send_request(KIND_REMOVE, value_t'(32'h7FFF_FFFF));
		send_request(KIND_REMOVE, value_t'(0));
		send_request(KIND_REMOVE, value_t'(32'hFFFF_FFFF));
		send_request(KIND_REMOVE, value_t'(32'h8000_0000));
		send_request(KIND_SEARCH, value_t'(32'h8000_0000));
		send_request(KIND_PUSH_BACK, value_t'(32'h5555_5555));
		send_request(KIND_PUSH_FRONT, value_t'(32'hAAAA_AAAA));
		send_request(KIND_SEARCH, value_t'(32'h5555_5555));
		send_request(KIND_REMOVE, value_t'(32'h5555_5555));
		send_request(KIND_REMOVE, value_t'(32'hAAAA_AAAA));
		send_request(KIND_PUSH_BACK, value_t'(32'h0000_0001));
		drain_results();

		// grow to a full pool, push into it, then shrink back and mix
		for (int round = 0; round < 2; round++) begin
			run_phase(45, 80, 10, 50);
			run_phase(45, 80, 10, 50);
			run_phase(30, 90, 5, 50);
			drain_results();
			run_phase(30, 40, 30, 70);
			run_phase(45, 15, 70, 90);
			run_phase(30, 15, 70, 90);
			drain_results();
		end

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/oll_pkg.sv
hw/rtl/oll_req_if.sv
hw/rtl/oll_rsp_if.sv
hw/rtl/oll_mem.sv
hw/rtl/oll_ctrl.sv
hw/rtl/ordered_list_with_search.sv
bench/tb_ordered_list_with_search.sv
